// ===== src/assert_macros.svh =====
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define CJD_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

`define CJD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`else

`define CJD_ASSERT_IMP(lbl, clk, rst, ante, cons)

`define CJD_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ===== src/cjd_pkg.sv =====
package cjd_pkg;

   localparam int YEAR_W  = 15;
   localparam int MONTH_W = 4;
   localparam int DAY_W   = 5;
   localparam int SEC_W   = 17;
   localparam int JD_W    = 40;

   localparam int REQ_DATA_W = 88;
   localparam int RSP_DATA_W = 88;

   // eleven register stages, the last one is the result register
   localparam int STAGES      = 11;
   localparam int CORE_STAGES = STAGES - 1;

   localparam logic KIND_TO_JD    = 1'b0;
   localparam logic KIND_TO_CIVIL = 1'b1;

   // round-up reciprocals, exact floor division over the stated operand range
   localparam int           RECIP_675_SH    = 42;
   localparam logic [32:0]  RECIP_675       =
      33'(((64'd1 << RECIP_675_SH) + 64'd674) / 64'd675);
   localparam int           RECIP_100_SH    = 21;
   localparam logic [14:0]  RECIP_100       =
      15'(((64'd1 << RECIP_100_SH) + 64'd99) / 64'd100);
   localparam int           RECIP_146097_SH = 42;
   localparam logic [24:0]  RECIP_146097    =
      25'(((64'd1 << RECIP_146097_SH) + 64'd146096) / 64'd146097);
   localparam int           RECIP_7305_SH   = 41;
   localparam logic [28:0]  RECIP_7305      =
      29'(((64'd1 << RECIP_7305_SH) + 64'd7304) / 64'd7305);
   localparam int           RECIP_306001_SH = 43;
   localparam logic [24:0]  RECIP_306001    =
      25'(((64'd1 << RECIP_306001_SH) + 64'd306000) / 64'd306001);

   typedef struct packed {
      logic                     err;
      logic signed [JD_W-1:0]   jd;
   } jd_res_type;

   typedef struct packed {
      logic                     err;
      logic signed [YEAR_W-1:0] year;
      logic [MONTH_W-1:0]       month;
      logic [DAY_W-1:0]         day;
      logic [SEC_W-1:0]         seconds;
   } civil_res_type;

   // floor(30.6001 * k)
   function automatic logic [8:0] month_offset(input logic [3:0] k);
      logic [8:0] v;
      case (k)
         4'd0:    v = 9'd0;
         4'd1:    v = 9'd30;
         4'd2:    v = 9'd61;
         4'd3:    v = 9'd91;
         4'd4:    v = 9'd122;
         4'd5:    v = 9'd153;
         4'd6:    v = 9'd183;
         4'd7:    v = 9'd214;
         4'd8:    v = 9'd244;
         4'd9:    v = 9'd275;
         4'd10:   v = 9'd306;
         4'd11:   v = 9'd336;
         4'd12:   v = 9'd367;
         4'd13:   v = 9'd397;
         4'd14:   v = 9'd428;
         4'd15:   v = 9'd459;
         default: v = 9'd0;
      endcase
      return v;
   endfunction

endpackage

// ===== src/cjd_civ2jd.sv =====
module cjd_civ2jd (
   input  logic                                   clock,
   input  logic [cjd_pkg::CORE_STAGES-1:0]        en,
   input  logic signed [cjd_pkg::YEAR_W-1:0]      year,
   input  logic [cjd_pkg::MONTH_W-1:0]            month,
   input  logic [cjd_pkg::DAY_W-1:0]              day,
   input  logic [cjd_pkg::SEC_W-1:0]              seconds,
   output cjd_pkg::jd_res_type                    res
);

   localparam int JD_W = cjd_pkg::JD_W;
   localparam int LAST = cjd_pkg::CORE_STAGES - 1;

   logic signed [14:0] y_in, y0_ff;
   logic [3:0]         mp_in, mp0_ff;
   logic               greg_in, greg0_ff, greg1_ff;
   logic               err_in, err0_ff, err1_ff, err2_ff, err3_ff, err4_ff;
   logic [4:0]         day0_ff, day1_ff;
   logic [16:0]        sec0_ff, sec1_ff, sec2_ff, sec3_ff, sec4_ff;

   logic [13:0]        yoff;
   logic [28:0]        q_prod;
   logic signed [25:0] y_ext, c_prod;
   logic [7:0]         q1_ff;
   logic signed [23:0] c1_ff;
   logic [8:0]         doff1_ff;

   logic signed [8:0]  a_val, b_in, b2_ff;
   logic signed [23:0] part_in, part2_ff;
   logic signed [23:0] days_in, days3_ff;
   logic [40:0]        prod_in, prod4_ff;

   cjd_pkg::jd_res_type res_in;
   cjd_pkg::jd_res_type pipe_ff [5:LAST];

   always_comb begin
      y_in    = (month < 4'd3) ? year - 15'sd1 : year;
      mp_in   = (month < 4'd3) ? month + 4'd13 : month + 4'd1;
      greg_in = (year > 15'sd1582) ||
                (year == 15'sd1582 && (month > 4'd10 || (month == 4'd10 && day >= 5'd15)));
      err_in  = (year < -15'sd4712) || (year > 15'sd9999) || (month < 4'd1) ||
                (month > 4'd12) || (day < 5'd1) || (seconds > 17'd86399);
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         y0_ff    <= y_in;
         mp0_ff   <= mp_in;
         day0_ff  <= day;
         sec0_ff  <= seconds;
         greg0_ff <= greg_in;
         err0_ff  <= err_in;
      end
   end

   // century term via reciprocal of 100 on an offset year
   always_comb begin
      yoff   = 14'(y0_ff + 15'sd4800);
      q_prod = 29'(yoff) * 29'(cjd_pkg::RECIP_100);
      y_ext  = {{11{y0_ff[14]}}, y0_ff};
      c_prod = y_ext * 26'sd1461;
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         q1_ff    <= q_prod[cjd_pkg::RECIP_100_SH +: 8];
         c1_ff    <= c_prod[25:2];
         doff1_ff <= cjd_pkg::month_offset(mp0_ff);
         day1_ff  <= day0_ff;
         sec1_ff  <= sec0_ff;
         greg1_ff <= greg0_ff;
         err1_ff  <= err0_ff;
      end
   end

   always_comb begin
      a_val   = $signed({1'b0, q1_ff}) - 9'sd48;
      b_in    = greg1_ff ? 9'sd2 - a_val + (a_val >>> 2) : 9'sd0;
      part_in = c1_ff + $signed({15'b0, doff1_ff}) + $signed({19'b0, day1_ff}) +
                24'sd1720994;
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         b2_ff    <= b_in;
         part2_ff <= part_in;
         sec2_ff  <= sec1_ff;
         err2_ff  <= err1_ff;
      end
   end

   assign days_in = part2_ff + $signed({{15{b2_ff[8]}}, b2_ff});

   always_ff @(posedge clock) begin
      if (en[3]) begin
         days3_ff <= days_in;
         sec3_ff  <= sec2_ff;
         err3_ff  <= err2_ff;
      end
   end

   assign prod_in = {{17{days3_ff[23]}}, days3_ff} * 41'd86400;

   always_ff @(posedge clock) begin
      if (en[4]) begin
         prod4_ff <= prod_in;
         sec4_ff  <= sec3_ff;
         err4_ff  <= err3_ff;
      end
   end

   always_comb begin
      res_in.err = err4_ff;
      res_in.jd  = prod4_ff[JD_W-1:0] + JD_W'(43200) + {{(JD_W-17){1'b0}}, sec4_ff};
   end

   // delay line so both directions leave the core together
   always_ff @(posedge clock) begin
      if (en[5]) begin
         pipe_ff[5] <= res_in;
      end
      for (int k = 6; k <= LAST; k++) begin
         if (en[k]) begin
            pipe_ff[k] <= pipe_ff[k-1];
         end
      end
   end

   assign res = pipe_ff[LAST];

endmodule

// ===== src/cjd_jd2civ.sv =====
module cjd_jd2civ (
   input  logic                                clock,
   input  logic [cjd_pkg::CORE_STAGES-1:0]     en,
   input  logic signed [cjd_pkg::JD_W-1:0]     jd_seconds,
   output cjd_pkg::civil_res_type              res
);

   logic [39:0]  tot;
   logic         bad;
   logic [31:0]  x0_ff, x1_ff;
   logic [6:0]   lo0_ff, lo1_ff;
   logic         err0_ff, err1_ff, err2_ff, err3_ff, err4_ff;
   logic         err5_ff, err6_ff, err7_ff, err8_ff, err9_ff;

   logic [64:0]  i_prod;
   logic [22:0]  i1_ff, i2_ff, i3_ff;

   logic [31:0]  r_full;
   logic         greg_in, greg2_ff, greg3_ff;
   logic [24:0]  n_full;
   logic [23:0]  n_in, n2_ff;
   logic [16:0]  f_in, f2_ff, f3_ff, f4_ff, f5_ff, f6_ff, f7_ff, f8_ff, f9_ff;

   logic [48:0]  a_prod;
   logic [6:0]   a3_ff;
   logic [22:0]  c_in, c4_ff, c5_ff, c6_ff;
   logic [27:0]  num_in, num5_ff;
   logic [56:0]  d_prod;
   logic [13:0]  d6_ff, d7_ff, d8_ff, d9_ff;
   logic [24:0]  e_prod;
   logic [9:0]   cme_in, cme7_ff, cme8_ff, cme9_ff;
   logic [23:0]  n8_in, n8_ff;
   logic [48:0]  g_prod;
   logic [3:0]   g9_ff;

   logic [9:0]          dom;
   logic [3:0]          mo_val;
   logic signed [15:0]  yr_val;

   always_comb begin
      bad = (jd_seconds < -40'sd43200) || (jd_seconds > 40'sd464300000000);
      tot = jd_seconds + 40'sd43200;
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         x0_ff   <= tot[38:7];
         lo0_ff  <= tot[6:0];
         err0_ff <= bad;
      end
   end

   // whole days: divide by 128, then by 675
   assign i_prod = 65'(x0_ff) * 65'(cjd_pkg::RECIP_675);

   always_ff @(posedge clock) begin
      if (en[1]) begin
         i1_ff   <= i_prod[cjd_pkg::RECIP_675_SH +: 23];
         x1_ff   <= x0_ff;
         lo1_ff  <= lo0_ff;
         err1_ff <= err0_ff;
      end
   end

   always_comb begin
      r_full  = x1_ff - 32'(i1_ff) * 32'd675;
      f_in    = {r_full[9:0], lo1_ff};
      greg_in = i1_ff > 23'd2299160;
      n_full  = {i1_ff, 2'b00} - 25'd7468865;
      n_in    = greg_in ? n_full[23:0] : 24'd0;
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         i2_ff    <= i1_ff;
         f2_ff    <= f_in;
         greg2_ff <= greg_in;
         n2_ff    <= n_in;
         err2_ff  <= err1_ff;
      end
   end

   assign a_prod = 49'(n2_ff) * 49'(cjd_pkg::RECIP_146097);

   always_ff @(posedge clock) begin
      if (en[3]) begin
         a3_ff    <= a_prod[cjd_pkg::RECIP_146097_SH +: 7];
         i3_ff    <= i2_ff;
         greg3_ff <= greg2_ff;
         f3_ff    <= f2_ff;
         err3_ff  <= err2_ff;
      end
   end

   assign c_in = greg3_ff ? i3_ff + 23'(a3_ff) - 23'(a3_ff >> 2) + 23'd1525
                          : i3_ff + 23'd1524;

   always_ff @(posedge clock) begin
      if (en[4]) begin
         c4_ff   <= c_in;
         f4_ff   <= f3_ff;
         err4_ff <= err3_ff;
      end
   end

   assign num_in = 28'({c4_ff, 4'b0000}) + 28'({c4_ff, 2'b00}) - 28'd2442;

   always_ff @(posedge clock) begin
      if (en[5]) begin
         num5_ff <= num_in;
         c5_ff   <= c4_ff;
         f5_ff   <= f4_ff;
         err5_ff <= err4_ff;
      end
   end

   assign d_prod = 57'(num5_ff) * 57'(cjd_pkg::RECIP_7305);

   always_ff @(posedge clock) begin
      if (en[6]) begin
         d6_ff   <= d_prod[cjd_pkg::RECIP_7305_SH +: 14];
         c6_ff   <= c5_ff;
         f6_ff   <= f5_ff;
         err6_ff <= err5_ff;
      end
   end

   always_comb begin
      e_prod = 25'(d6_ff) * 25'd1461;
      cme_in = 10'(c6_ff - e_prod[24:2]);
   end

   always_ff @(posedge clock) begin
      if (en[7]) begin
         cme7_ff <= cme_in;
         d7_ff   <= d6_ff;
         f7_ff   <= f6_ff;
         err7_ff <= err6_ff;
      end
   end

   assign n8_in = 24'(cme7_ff) * 24'd10000;

   always_ff @(posedge clock) begin
      if (en[8]) begin
         n8_ff   <= n8_in;
         cme8_ff <= cme7_ff;
         d8_ff   <= d7_ff;
         f8_ff   <= f7_ff;
         err8_ff <= err7_ff;
      end
   end

   assign g_prod = 49'(n8_ff) * 49'(cjd_pkg::RECIP_306001);

   always_ff @(posedge clock) begin
      if (en[9]) begin
         g9_ff   <= g_prod[cjd_pkg::RECIP_306001_SH +: 4];
         cme9_ff <= cme8_ff;
         d9_ff   <= d8_ff;
         f9_ff   <= f8_ff;
         err9_ff <= err8_ff;
      end
   end

   always_comb begin
      dom    = cme9_ff - {1'b0, cjd_pkg::month_offset(g9_ff)};
      mo_val = (g9_ff <= 4'd13) ? g9_ff - 4'd1 : g9_ff - 4'd13;
      yr_val = $signed({2'b00, d9_ff}) - ((mo_val > 4'd2) ? 16'sd4716 : 16'sd4715);
      res.err     = err9_ff || (yr_val > 16'sd9999);
      res.year    = yr_val[14:0];
      res.month   = mo_val;
      res.day     = dom[4:0];
      res.seconds = f9_ff;
   end

endmodule

// ===== src/civil_julian_date_converter_top.sv =====
// civil date / julian date converter
// req channel: one request per accepted beat; req_tuser picks the direction
// (0 civil date to julian date, 1 julian date to civil date) and req_tdata
// carries both operand sets, the unused one is ignored
// rsp channel: one result per request, in request order; rsp_tuser is the
// status flag (1 when the operands are out of range, all data bits then 0)
// fields of the other direction are returned as 0
// pipeline: results come out of the eleven register stages, ten in the
// julian-to-civil core plus the result register (four reciprocal divides and
// three constant multiplies, each followed by a register); the civil path is
// delayed to match
// throughput: one request per cycle, sustained unless all stages are full and rsp_tready is low
// stall: each stage advances when rsp_tready is high or when it or any stage
// after it is empty, so bubbles are squeezed out; req_tready falls only when
// all stages are full and rsp_tready is low; a held result keeps its value
// reset: all stage valid flags clear, no result is pending
`include "assert_macros.svh"

module civil_julian_date_converter_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // year[14:0] month[18:15] day[23:19] seconds_of_day[40:24] jd_seconds[80:41]
   input  logic [cjd_pkg::REQ_DATA_W-1:0]      req_tdata,
   // kind
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // jd_out[39:0] year_out[54:40] month_out[58:55] day_out[63:59] seconds_out[80:64]
   output logic [cjd_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // status
   output logic                                rsp_tuser
);

   localparam int STAGES = cjd_pkg::STAGES;
   localparam int LAST   = STAGES - 1;
   localparam int JD_W   = cjd_pkg::JD_W;
   localparam int RSP_W  = cjd_pkg::RSP_DATA_W;

   logic [STAGES-1:0] vld_ff, vld_in, en;
   logic [STAGES-1:0] kind_ff;

   logic signed [cjd_pkg::YEAR_W-1:0] req_year;
   logic [cjd_pkg::MONTH_W-1:0]       req_month;
   logic [cjd_pkg::DAY_W-1:0]         req_day;
   logic [cjd_pkg::SEC_W-1:0]         req_seconds;
   logic signed [cjd_pkg::JD_W-1:0]   req_jd;

   cjd_pkg::jd_res_type    jd_res;
   cjd_pkg::civil_res_type civ_res;

   logic [cjd_pkg::RSP_DATA_W-1:0] rsp_data_in, rsp_data_ff;
   logic                           rsp_status_in, rsp_status_ff;
   logic                           rsp_to_jd;

   assign req_year    = req_tdata[14:0];
   assign req_month   = req_tdata[18:15];
   assign req_day     = req_tdata[23:19];
   assign req_seconds = req_tdata[40:24];
   assign req_jd      = req_tdata[80:41];

   always_comb begin
      for (int k = 0; k < STAGES; k++) begin
         en[k] = rsp_tready || (((~vld_ff) >> k) != '0);
      end
      vld_in[0] = en[0] ? req_tvalid : vld_ff[0];
      for (int k = 1; k < STAGES; k++) begin
         vld_in[k] = en[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         kind_ff[0] <= req_tuser;
      end
      for (int k = 1; k < STAGES; k++) begin
         if (en[k]) begin
            kind_ff[k] <= kind_ff[k-1];
         end
      end
   end

   cjd_civ2jd u_civ2jd (
      .clock   (clock),
      .en      (en[LAST-1:0]),
      .year    (req_year),
      .month   (req_month),
      .day     (req_day),
      .seconds (req_seconds),
      .res     (jd_res)
   );

   cjd_jd2civ u_jd2civ (
      .clock      (clock),
      .en         (en[LAST-1:0]),
      .jd_seconds (req_jd),
      .res        (civ_res)
   );

   always_comb begin
      rsp_data_in = '0;
      case (kind_ff[LAST-1])
         cjd_pkg::KIND_TO_JD: begin
            rsp_status_in = jd_res.err;
            if (!jd_res.err) begin
               rsp_data_in[39:0] = jd_res.jd;
            end
         end
         cjd_pkg::KIND_TO_CIVIL: begin
            rsp_status_in = civ_res.err;
            if (!civ_res.err) begin
               rsp_data_in[54:40] = civ_res.year;
               rsp_data_in[58:55] = civ_res.month;
               rsp_data_in[63:59] = civ_res.day;
               rsp_data_in[80:64] = civ_res.seconds;
            end
         end
         default: begin
            rsp_status_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en[LAST]) begin
         rsp_data_ff   <= rsp_data_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign req_tready = en[0];
   assign rsp_tvalid = vld_ff[LAST];
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;

   assign rsp_to_jd = rsp_tvalid && (kind_ff[LAST] == cjd_pkg::KIND_TO_JD);

   `CJD_ASSERT_IMP(err_result_zero_a, clock, reset, rsp_tvalid && rsp_tuser, rsp_tdata == '0)
   `CJD_ASSERT_IMP(stall_only_when_full_a, clock, reset, !req_tready, &vld_ff)
   `CJD_ASSERT_IMP(to_jd_civil_zero_a, clock, reset, rsp_to_jd, rsp_tdata[RSP_W-1:JD_W] == '0)
   `CJD_ASSERT_NEXT(accept_fills_first_a, clock, reset, req_tvalid && req_tready, vld_ff[0])

endmodule
